FILE: sv/cbmt_pkg.sv
`timescale 1ns / 1ps

package cbmt_pkg;

    localparam int NUM_COUNTERS = 16;

    localparam int REQ_TYPE_W = 2;
    localparam int REQ_INDEX_W = 4;
    localparam int VALUE_W = 16;
    localparam int NUM_AT_MAX_W = 5;

    localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
    localparam int TREE_LVLS = $clog2(NUM_COUNTERS);
    localparam int TREE_SIZE = 1 << TREE_LVLS;
    localparam int CNT_W = $clog2(NUM_COUNTERS + 1);
    localparam int SUM_W = (CNT_W > NUM_AT_MAX_W) ? CNT_W : NUM_AT_MAX_W;
    localparam int NUM_MAX_LIMIT = 31;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [REQ_TYPE_W-1:0] REQ_INC = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_DEC = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLR = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_QRY = 2'd3;

    localparam logic signed [VALUE_W-1:0] CNT_MAX_VAL = 16'sh7FFF;
    localparam logic signed [VALUE_W-1:0] CNT_MIN_VAL = 16'sh8000;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] op;
        logic                  in_range;
        logic [IDX_W-1:0]      idx;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

endpackage

FILE: sv/cbmt_req_if.sv
`timescale 1ns / 1ps

interface cbmt_req_if;
    logic                               valid;
    logic                               ready;
    logic [cbmt_pkg::REQ_TYPE_W-1:0]    req_type;
    logic [cbmt_pkg::REQ_INDEX_W-1:0]   counter_index;

    modport source (output valid, output req_type, output counter_index, input ready);
    modport sink (input valid, input req_type, input counter_index, output ready);
endinterface

FILE: sv/cbmt_rsp_if.sv
`timescale 1ns / 1ps

interface cbmt_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [cbmt_pkg::VALUE_W-1:0]    counter_value;
    logic signed [cbmt_pkg::VALUE_W-1:0]    max_value;
    logic [cbmt_pkg::NUM_AT_MAX_W-1:0]      num_at_max;

    modport source (output valid, output counter_value, output max_value,
                    output num_at_max, input ready);
    modport sink (input valid, input counter_value, input max_value,
                  input num_at_max, output ready);
endinterface

FILE: sv/counter_bank_max_tracker.sv
`timescale 1ns / 1ps

// A bank of signed 16-bit saturating counters, all zero after reset. Each request item
// increments, decrements, clears or only queries one counter and yields one result item:
// that counter's new value (zero for an index beyond the bank), the bank maximum and how
// many counters hold it (saturating at 31). Requests enter a two-entry queue; the back end
// handles each item in a registered max tree step and then an equality count step, and
// overlaps the count step with the next counter update. The result is written to an
// output register once that register is free and
// is held in the output register until taken.
module counter_bank_max_tracker (
    input  logic        clk,
    input  logic        rst_n,
    cbmt_req_if.sink    req,
    cbmt_rsp_if.source  rsp
);

    cbmt_pkg::queue_head_t  head;
    logic                   pop;

    cbmt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pop   (pop),
        .head  (head)
    );

    cbmt_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

FILE: sv/cbmt_front.sv
`timescale 1ns / 1ps

module cbmt_front (
    input  logic                        clk,
    input  logic                        rst_n,
    cbmt_req_if.sink                    req,
    input  logic                        pop,
    output cbmt_pkg::queue_head_t       head
);

    cbmt_pkg::cmd_t                 q_reg [cbmt_pkg::QUEUE_DEPTH];
    logic [cbmt_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [cbmt_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [cbmt_pkg::QCNT_W-1:0]    count_reg;
    logic [cbmt_pkg::QCNT_W-1:0]    count_next;
    cbmt_pkg::cmd_t                 cmd_in;
    logic                           push;
    logic                           do_pop;

    // Classify the request: a counter outside the bank is never written.
    always_comb
    begin
        cmd_in.op = req.req_type;
        cmd_in.in_range = (req.counter_index < cbmt_pkg::NUM_COUNTERS);
        cmd_in.idx = cbmt_pkg::IDX_W'(req.counter_index);
    end

    assign req.ready = (count_reg != cbmt_pkg::QCNT_W'(cbmt_pkg::QUEUE_DEPTH));
    assign push = req.valid && req.ready;
    assign do_pop = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.cmd = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: sv/cbmt_back.sv
`timescale 1ns / 1ps

module cbmt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cbmt_pkg::queue_head_t       head,
    output logic                        pop,
    cbmt_rsp_if.source                  rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAX  = 2'd1;
    localparam logic [1:0] ST_CNT  = 2'd2;

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    cbmt_pkg::value_t                   bank_reg [cbmt_pkg::NUM_COUNTERS];
    cbmt_pkg::value_t                   named_reg;
    cbmt_pkg::value_t                   named_next;
    cbmt_pkg::value_t                   max_reg;
    logic                               out_valid_reg;
    cbmt_pkg::value_t                   out_value_reg;
    cbmt_pkg::value_t                   out_max_reg;
    logic [cbmt_pkg::NUM_AT_MAX_W-1:0]  out_num_reg;
    logic [cbmt_pkg::NUM_AT_MAX_W-1:0]  num_sat;
    logic [cbmt_pkg::SUM_W-1:0]         eq_sum;
    cbmt_pkg::value_t                   cur_value;
    cbmt_pkg::value_t                   new_value;
    cbmt_pkg::value_t                   tree [cbmt_pkg::TREE_LVLS+1][cbmt_pkg::TREE_SIZE];
    logic                               out_free;
    logic                               finish;

    assign out_free = !out_valid_reg || rsp.ready;
    assign finish = (state_reg == ST_CNT) && out_free;
    // The next update overlaps the count cycle: the count reads the bank
    // before the edge that writes it.
    assign pop = head.valid && ((state_reg == ST_IDLE) || finish);

    always_comb
    begin
        cur_value = bank_reg[head.cmd.idx];
        case (head.cmd.op)
            cbmt_pkg::REQ_INC:
                new_value = (cur_value != cbmt_pkg::CNT_MAX_VAL) ? cur_value + 1'b1 : cur_value;
            cbmt_pkg::REQ_DEC:
                new_value = (cur_value != cbmt_pkg::CNT_MIN_VAL) ? cur_value - 1'b1 : cur_value;
            cbmt_pkg::REQ_CLR:
                new_value = '0;
            default:
                new_value = cur_value;
        endcase
        named_next = head.cmd.in_range ? new_value : '0;
    end

    // Max tree over the bank, padded with the most negative value.
    always_comb
    begin
        for (int k = 0; k < cbmt_pkg::TREE_SIZE; k++)
        begin
            tree[0][k] = (k < cbmt_pkg::NUM_COUNTERS) ? bank_reg[k] : cbmt_pkg::CNT_MIN_VAL;
        end
        for (int l = 0; l < cbmt_pkg::TREE_LVLS; l++)
        begin
            for (int k = 0; k < cbmt_pkg::TREE_SIZE; k++)
            begin
                tree[l+1][k] = cbmt_pkg::CNT_MIN_VAL;
            end
            for (int k = 0; k < cbmt_pkg::TREE_SIZE / 2; k++)
            begin
                tree[l+1][k] = (tree[l][2*k+1] > tree[l][2*k]) ? tree[l][2*k+1] : tree[l][2*k];
            end
        end
    end

    always_comb
    begin
        eq_sum = '0;
        for (int k = 0; k < cbmt_pkg::NUM_COUNTERS; k++)
        begin
            eq_sum = eq_sum + cbmt_pkg::SUM_W'(bank_reg[k] == max_reg);
        end
        if (eq_sum > cbmt_pkg::SUM_W'(cbmt_pkg::NUM_MAX_LIMIT))
        begin
            num_sat = cbmt_pkg::NUM_AT_MAX_W'(cbmt_pkg::NUM_MAX_LIMIT);
        end
        else
        begin
            num_sat = cbmt_pkg::NUM_AT_MAX_W'(eq_sum);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (pop)
                begin
                    state_next = ST_MAX;
                end
            ST_MAX:
                state_next = ST_CNT;
            ST_CNT:
                if (finish)
                begin
                    state_next = pop ? ST_MAX : ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < cbmt_pkg::NUM_COUNTERS; k++)
            begin
                bank_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop && head.cmd.in_range)
            begin
                bank_reg[head.cmd.idx] <= new_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            named_reg <= named_next;
        end
        if (state_reg == ST_MAX)
        begin
            max_reg <= tree[cbmt_pkg::TREE_LVLS][0];
        end
        if (finish)
        begin
            out_value_reg <= named_reg;
            out_max_reg <= max_reg;
            out_num_reg <= num_sat;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.counter_value = out_value_reg;
    assign rsp.max_value = out_max_reg;
    assign rsp.num_at_max = out_num_reg;

endmodule

FILE: sv/cbmt_checker.sv
`timescale 1ns / 1ps

module cbmt_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic signed [cbmt_pkg::VALUE_W-1:0] rsp_counter_value,
    input  logic signed [cbmt_pkg::VALUE_W-1:0] rsp_max_value,
    input  logic [cbmt_pkg::NUM_AT_MAX_W-1:0]   rsp_num_at_max
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_counter_value) && $stable(rsp_max_value)
            && $stable(rsp_num_at_max))
        else $error("result changed while stalled");

    a_num_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_num_at_max != '0)
        else $error("no counter reported at the maximum");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid)
        else $error("result shown during reset");

endmodule

bind counter_bank_max_tracker cbmt_checker u_cbmt_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_counter_value (rsp.counter_value),
    .rsp_max_value     (rsp.max_value),
    .rsp_num_at_max    (rsp.num_at_max)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 10;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        cbmt_pkg::value_t                    value;
        cbmt_pkg::value_t                    peak;
        logic [cbmt_pkg::NUM_AT_MAX_W-1:0]   peak_count;
    } bank_result_t;

    logic clk;
    logic rst_n;

    cbmt_req_if req_if ();
    cbmt_rsp_if rsp_if ();

    counter_bank_max_tracker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    cbmt_pkg::value_t bank_model [cbmt_pkg::NUM_COUNTERS];
    bank_result_t     pending_results [$];
    int               mismatch_count;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_stall_pct;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one request to the local copy of the bank and returns the result it should produce.
    function automatic bank_result_t apply_to_bank(input logic [cbmt_pkg::REQ_TYPE_W-1:0] op,
                                                   input logic [cbmt_pkg::REQ_INDEX_W-1:0] idx);
        bank_result_t     r;
        cbmt_pkg::value_t v;
        int               n;
        r.value = '0;
        if (idx < cbmt_pkg::NUM_COUNTERS)
        begin
            v = bank_model[idx];
            case (op)
                cbmt_pkg::REQ_INC:
                begin
                    if (v != cbmt_pkg::CNT_MAX_VAL)
                        v = v + cbmt_pkg::value_t'(1);
                end
                cbmt_pkg::REQ_DEC:
                begin
                    if (v != cbmt_pkg::CNT_MIN_VAL)
                        v = v - cbmt_pkg::value_t'(1);
                end
                cbmt_pkg::REQ_CLR: v = '0;
                default: ;
            endcase
            bank_model[idx] = v;
            r.value = v;
        end
        r.peak = bank_model[0];
        for (int k = 1; k < cbmt_pkg::NUM_COUNTERS; k++)
        begin
            if (bank_model[k] > r.peak)
                r.peak = bank_model[k];
        end
        n = 0;
        for (int k = 0; k < cbmt_pkg::NUM_COUNTERS; k++)
        begin
            if (bank_model[k] == r.peak && n < cbmt_pkg::NUM_MAX_LIMIT)
                n++;
        end
        r.peak_count = n[cbmt_pkg::NUM_AT_MAX_W-1:0];
        return r;
    endfunction

    // Requests are predicted when accepted; results are checked in order when taken.
    always @(posedge clk)
    begin
        bank_result_t exp_r;
        bank_result_t pred_r;
        if (rst_n && req_if.valid && req_if.ready)
        begin
            pred_r = apply_to_bank(req_if.req_type, req_if.counter_index);
            pending_results.insert(pending_results.size(), pred_r);
        end
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result: value %0d max %0d count %0d",
                             rsp_if.counter_value, rsp_if.max_value, rsp_if.num_at_max);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (rsp_if.counter_value !== exp_r.value || rsp_if.max_value !== exp_r.peak
                    || rsp_if.num_at_max !== exp_r.peak_count)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("mismatch: expected value %0d max %0d count %0d, got %0d %0d %0d",
                                 exp_r.value, exp_r.peak, exp_r.peak_count, rsp_if.counter_value,
                                 rsp_if.max_value, rsp_if.num_at_max);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input logic [cbmt_pkg::REQ_TYPE_W-1:0] op,
                                input logic [cbmt_pkg::REQ_INDEX_W-1:0] idx);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= op;
        req_if.counter_index <= idx;
        do
            @(posedge clk);
        while (!req_if.ready);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic test_basic_ops();
        set_idling(0, 0);
        send_request(cbmt_pkg::REQ_QRY, 4'd0);
        send_request(cbmt_pkg::REQ_INC, 4'd0);
        send_request(cbmt_pkg::REQ_INC, 4'd15);
        send_request(cbmt_pkg::REQ_QRY, 4'd15);
        send_request(cbmt_pkg::REQ_DEC, 4'd0);
        send_request(cbmt_pkg::REQ_CLR, 4'd15);
        send_request(cbmt_pkg::REQ_CLR, 4'd3);
        send_request(cbmt_pkg::REQ_INC, 4'd7);
        send_request(cbmt_pkg::REQ_INC, 4'd7);
        send_request(cbmt_pkg::REQ_QRY, 4'd3);
        send_request(cbmt_pkg::REQ_DEC, 4'd7);
        send_request(cbmt_pkg::REQ_QRY, 4'd7);
        send_request(cbmt_pkg::REQ_DEC, 4'd15);
        send_request(cbmt_pkg::REQ_CLR, 4'd7);
    endtask

    // Drives every counter below zero so the bank maximum itself goes negative.
    task automatic test_negative_bank();
        for (int k = 0; k < cbmt_pkg::NUM_COUNTERS; k++)
            send_request(cbmt_pkg::REQ_DEC, k[cbmt_pkg::REQ_INDEX_W-1:0]);
        send_request(cbmt_pkg::REQ_DEC, 4'd4);
        send_request(cbmt_pkg::REQ_QRY, 4'd2);
        send_request(cbmt_pkg::REQ_INC, 4'd4);
        send_request(cbmt_pkg::REQ_INC, 4'd4);
        send_request(cbmt_pkg::REQ_CLR, 4'd0);
        send_request(cbmt_pkg::REQ_DEC, 4'd0);
    endtask

    // Pushes one counter well above the rest and another well below them.
    task automatic test_long_walk();
        set_idling(0, 0);
        send_request(cbmt_pkg::REQ_CLR, 4'd5);
        send_request(cbmt_pkg::REQ_CLR, 4'd9);
        repeat (20)
            send_request(cbmt_pkg::REQ_INC, 4'd5);
        repeat (20)
            send_request(cbmt_pkg::REQ_DEC, 4'd9);
        send_request(cbmt_pkg::REQ_QRY, 4'd9);
        send_request(cbmt_pkg::REQ_QRY, 4'd5);
        send_request(cbmt_pkg::REQ_CLR, 4'd5);
        send_request(cbmt_pkg::REQ_CLR, 4'd9);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int stall_pct);
        logic [cbmt_pkg::REQ_TYPE_W-1:0]  op;
        logic [cbmt_pkg::REQ_INDEX_W-1:0] idx;
        int                               pick;
        set_idling(send_pct, stall_pct);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                op = cbmt_pkg::REQ_INC;
            else if (pick < 60)
                op = cbmt_pkg::REQ_DEC;
            else if (pick < 75)
                op = cbmt_pkg::REQ_CLR;
            else
                op = cbmt_pkg::REQ_QRY;
            // Favoring a few counters lets them pull away and contest the maximum.
            if ($urandom_range(0, 1) == 0)
                idx = cbmt_pkg::REQ_INDEX_W'($urandom_range(0, 3));
            else
                idx = cbmt_pkg::REQ_INDEX_W'($urandom_range(0, cbmt_pkg::NUM_COUNTERS - 1));
            send_request(op, idx);
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < cbmt_pkg::NUM_COUNTERS; k++)
            bank_model[k] = '0;
        req_if.valid = 1'b0;
        req_if.req_type = cbmt_pkg::REQ_QRY;
        req_if.counter_index = '0;
        rst_n = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_negative_bank();
        test_long_walk();
        test_random_traffic(130, 0, 0);
        test_random_traffic(130, 48, 0);
        test_random_traffic(130, 0, 48);
        test_random_traffic(130, 35, 35);

        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
